### rtl/core/lbgq_pkg.sv
// Shared types, constants and geometry helpers for the level bucket geometry query.
`default_nettype none

package lbgq_pkg;

  localparam int unsigned NumLevels = 11;
  localparam logic [3:0]  TopLevel  = 4'(NumLevels - 1);
  localparam logic [31:0] EmptyMark = '1;

  typedef enum logic [2:0] {
    StIdle,
    StCurr,
    StSnap,
    StFinC,
    StFinS,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic curr;
    logic snap;
    logic fin_c;
    logic fin_s;
  } ctrl_t;

  typedef struct packed {
    logic [31:0] curr_count;
    logic [31:0] snap_count;
    logic [31:0] oldest_in_curr;
    logic [31:0] oldest_in_snap;
    logic        level_spills;
    logic [3:0]  max_merge_level;
    logic        bad_query;
  } result_t;

  // 2^(2l+1)
  function automatic logic [31:0] half_of(logic [3:0] l);
    return 32'd1 << {l, 1'b1};
  endfunction

  // 2^(2l+2)
  function automatic logic [31:0] size_of(logic [3:0] l);
    logic [4:0] sh;
    sh = 5'({l, 1'b0}) + 5'd2;
    return 32'd1 << sh;
  endfunction

  function automatic logic spills_at(logic [31:0] ledger, logic [3:0] l);
    logic hit;
    hit = ((ledger & (half_of(l) - 32'd1)) == 32'd0);
    return (l != TopLevel) && hit;
  endfunction

  // lowest level that does not spill, capped at the top level
  function automatic logic [3:0] max_merge(logic [31:0] ledger);
    logic [3:0] mm;
    mm = TopLevel;
    for (int i = int'(NumLevels) - 2; i >= 0; i--) begin
      if (!spills_at(ledger, 4'(i))) mm = 4'(i);
    end
    return mm;
  endfunction

endpackage

`default_nettype wire

### rtl/core/level_bucket_geometry_query.sv
// A request steps through StCurr and StSnap for each level up to the queried one, then
// StFinC, StFinS and StDone; a bad request goes straight to StDone. One request at a time;
// the sequencer drives every step of every level through the shared subtractor.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops out_valid_o.
`default_nettype none

module level_bucket_geometry_query (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] ledger_i,
  input  wire logic [3:0]  level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      curr_count_o,
  output logic [31:0]      snap_count_o,
  output logic [31:0]      oldest_in_curr_o,
  output logic [31:0]      oldest_in_snap_o,
  output logic             level_spills_o,
  output logic [3:0]       max_merge_level_o,
  output logic             bad_query_o
);

  lbgq_pkg::ctrl_t   ctrl;
  lbgq_pkg::result_t result;
  lbgq_pkg::result_t res_q;
  logic [3:0] lvl;
  logic       start, bad, out_free, xfer;
  logic       out_valid_q, out_valid_d;

  assign start    = in_valid_i && in_ready_o;
  assign bad      = (ledger_i == 32'd0) || (level_i >= lbgq_pkg::TopLevel + 4'd1);
  assign out_free = !out_valid_q || out_ready_i;

  lbgq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .bad_i      (bad),
    .level_i    (level_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .lvl_o      (lvl),
    .in_ready_o (in_ready_o),
    .xfer_o     (xfer)
  );

  lbgq_dp u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .lvl_i    (lvl),
    .ledger_i (ledger_i),
    .level_i  (level_i),
    .bad_i    (bad),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (xfer) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) res_q <= result;
  end

  assign out_valid_o       = out_valid_q;
  assign curr_count_o      = res_q.curr_count;
  assign snap_count_o      = res_q.snap_count;
  assign oldest_in_curr_o  = res_q.oldest_in_curr;
  assign oldest_in_snap_o  = res_q.oldest_in_snap;
  assign level_spills_o    = res_q.level_spills;
  assign max_merge_level_o = res_q.max_merge_level;
  assign bad_query_o       = res_q.bad_query;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o)
    else $error("request taken while a previous one is still in work");

  a_bad_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_query_o |-> curr_count_o == 32'd0 && snap_count_o == 32'd0 &&
      oldest_in_curr_o == 32'd0 && oldest_in_snap_o == 32'd0 && !level_spills_o &&
      max_merge_level_o == 4'd0)
    else $error("bad request result carries nonzero fields");

  a_merge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_query_o |-> max_merge_level_o <= lbgq_pkg::TopLevel)
    else $error("merge level beyond top level");

  a_empty_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_query_o && snap_count_o == 32'd0 |->
      oldest_in_snap_o == lbgq_pkg::EmptyMark)
    else $error("empty snapshot bucket without empty mark");

  a_xfer_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> out_free)
    else $error("result overwrote an untaken one");

endmodule

`default_nettype wire

### rtl/core/lbgq_seq.sv
// Sequencer: walks the levels from zero up to the queried one, two steps per level.
`default_nettype none

module lbgq_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            bad_i,
  input  wire logic [3:0]      level_i,
  input  wire logic            out_free_i,
  output lbgq_pkg::ctrl_t      ctrl_o,
  output logic [3:0]           lvl_o,
  output logic                 in_ready_o,
  output logic                 xfer_o
);

  lbgq_pkg::state_e state_q, state_d;
  logic [3:0] lvl_q, lvl_d;
  logic [3:0] lev_q, lev_d;
  logic       last;

  assign last = (lvl_q == lev_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbgq_pkg::StIdle: begin
        if (start_i) state_d = bad_i ? lbgq_pkg::StDone : lbgq_pkg::StCurr;
      end
      lbgq_pkg::StCurr: state_d = lbgq_pkg::StSnap;
      lbgq_pkg::StSnap: state_d = last ? lbgq_pkg::StFinC : lbgq_pkg::StCurr;
      lbgq_pkg::StFinC: state_d = lbgq_pkg::StFinS;
      lbgq_pkg::StFinS: state_d = lbgq_pkg::StDone;
      lbgq_pkg::StDone: begin
        if (out_free_i) state_d = lbgq_pkg::StIdle;
      end
      default: state_d = lbgq_pkg::StIdle;
    endcase
  end

  always_comb begin
    lvl_d = lvl_q;
    lev_d = lev_q;
    if (start_i) begin
      lvl_d = 4'd0;
      lev_d = level_i;
    end else if (state_q == lbgq_pkg::StSnap && !last) begin
      lvl_d = lvl_q + 4'd1;
    end
  end

  always_comb begin
    in_ready_o   = (state_q == lbgq_pkg::StIdle);
    ctrl_o.load  = start_i;
    ctrl_o.curr  = (state_q == lbgq_pkg::StCurr);
    ctrl_o.snap  = (state_q == lbgq_pkg::StSnap);
    ctrl_o.fin_c = (state_q == lbgq_pkg::StFinC);
    ctrl_o.fin_s = (state_q == lbgq_pkg::StFinS);
    xfer_o       = (state_q == lbgq_pkg::StDone) && out_free_i;
    lvl_o        = lvl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbgq_pkg::StIdle;
      lvl_q   <= 4'd0;
      lev_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      lev_q   <= lev_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lbgq_dp.sv
// Datapath: bucket counts per level through one shared 32-bit subtractor.
`default_nettype none

module lbgq_dp (
  input  wire logic            clk_i,
  input  wire lbgq_pkg::ctrl_t ctrl_i,
  input  wire logic [3:0]      lvl_i,
  input  wire logic [31:0]     ledger_i,
  input  wire logic [3:0]      level_i,
  input  wire logic            bad_i,
  output lbgq_pkg::result_t    result_o
);

  logic [31:0] ledger_q;
  logic        bad_q;
  logic        spill_q;
  logic [3:0]  mm_q;
  // rem = ledger minus everything held below the current level
  logic [31:0] rem_q;
  // t = rem minus the current bucket of this level
  logic [31:0] t_q;
  logic [31:0] c_q, s_q, oc_q, os_q;

  logic [31:0] c_next, s_next;
  logic [31:0] half_l, r_low;
  logic [4:0]  ph_sh;
  logic [1:0]  k;
  logic [2:0]  k_inc;
  logic [31:0] op_a, op_b, diff;

  always_comb begin
    half_l = lbgq_pkg::half_of(lvl_i);
    r_low  = ledger_q & (half_l - 32'd1);
    ph_sh  = {lvl_i - 4'd1, 1'b1};
    // round down to half of the level below, then add one such half
    k      = 2'(r_low >> ph_sh);
    k_inc  = {1'b0, k} + 3'd1;
    if (lvl_i == 4'd0) begin
      c_next = (ledger_q == 32'd1) ? 32'd1 : 32'd1 + {31'd0, ledger_q[0]};
    end else if (lvl_i != lbgq_pkg::TopLevel && ledger_q >= half_l) begin
      c_next = {29'd0, k_inc} << ph_sh;
    end else begin
      c_next = rem_q;
    end

    if (lvl_i == lbgq_pkg::TopLevel) begin
      s_next = 32'd0;
    end else if (ledger_q >= lbgq_pkg::size_of(lvl_i)) begin
      s_next = half_l;
    end else begin
      s_next = t_q;
    end
  end

  // shared subtractor; subtracting all ones gives the +1 for the oldest marks
  always_comb begin
    if (ctrl_i.curr) begin
      op_a = rem_q;
      op_b = c_next;
    end else if (ctrl_i.snap) begin
      op_a = t_q;
      op_b = s_next;
    end else if (ctrl_i.fin_c) begin
      op_a = t_q;
      op_b = '1;
    end else begin
      op_a = rem_q;
      op_b = '1;
    end
    diff = op_a - op_b;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ledger_q <= ledger_i;
      rem_q    <= ledger_i;
      bad_q    <= bad_i;
      spill_q  <= lbgq_pkg::spills_at(ledger_i, level_i);
      mm_q     <= lbgq_pkg::max_merge(ledger_i);
    end
    if (ctrl_i.curr) begin
      c_q <= c_next;
      t_q <= diff;
    end
    if (ctrl_i.snap) begin
      s_q   <= s_next;
      rem_q <= diff;
    end
    if (ctrl_i.fin_c) oc_q <= diff;
    if (ctrl_i.fin_s) os_q <= diff;
  end

  always_comb begin
    if (bad_q) begin
      result_o           = '0;
      result_o.bad_query = 1'b1;
    end else begin
      result_o.curr_count      = c_q;
      result_o.snap_count      = s_q;
      result_o.oldest_in_curr  = (c_q == 32'd0) ? lbgq_pkg::EmptyMark : oc_q;
      result_o.oldest_in_snap  = (s_q == 32'd0) ? lbgq_pkg::EmptyMark : os_q;
      result_o.level_spills    = spill_q;
      result_o.max_merge_level = mm_q;
      result_o.bad_query       = 1'b0;
    end
  end

endmodule

`default_nettype wire
